// ----- design/ips_pkg.sv -----
package ips_pkg;

   localparam int SOURCE_WIDTH_DEF  = 320;
   localparam int SOURCE_HEIGHT_DEF = 200;
   localparam int MAX_SCALE_DEF     = 8;

   localparam int BYTES_PER_PIXEL = 4;
   localparam int BPP_SHIFT       = 2;

   localparam int ADDR_W   = 25;
   localparam int WORD_W   = 24;
   localparam int CHAN_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int SW_W     = 13;
   localparam int SCALE_W  = 4;
   localparam int REP_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SW_W-1:0]    SCREEN_WIDTH_RESET = SW_W'(320);
   localparam logic [SCALE_W-1:0] SCALE_RESET        = SCALE_W'(1);

   localparam logic CSR_SCREEN_WIDTH = 1'b0;
   localparam logic CSR_SCALE        = 1'b1;

   typedef enum logic [1:0] {
      KIND_GAMMA   = 2'd0,
      KIND_PALETTE = 2'd1,
      KIND_PIXEL   = 2'd2,
      KIND_FRAME   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [INDEX_W-1:0] entry_index;
      logic [CHAN_W-1:0]  gamma_value;
      logic [CHAN_W-1:0]  raw_red;
      logic [CHAN_W-1:0]  raw_green;
      logic [CHAN_W-1:0]  raw_blue;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic [WORD_W-1:0] pixel_word;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [WORD_W-1:0] word;
   } rep_load_type;

endpackage

// ----- design/ips_ram.sv -----
module ips_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/ips_replicator.sv -----
module ips_replicator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load_valid,
   output logic                         load_ready,
   input  ips_pkg::rep_load_type        load,
   input  logic [ips_pkg::SCALE_W-1:0]  s_eff,
   input  logic [ips_pkg::ADDR_W-1:0]   stride,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ips_pkg::rsp_type             rsp_payload
);

   import ips_pkg::*;

   logic              vld_ff, vld_in;
   logic [REP_W-1:0]  rr_ff, rr_in;
   logic [REP_W-1:0]  cc_ff, cc_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [REP_W-1:0]  last_idx;
   logic              last;

   assign last_idx   = REP_W'(s_eff - SCALE_W'(1));
   assign last       = (rr_ff == last_idx) && (cc_ff == last_idx);
   assign load_ready = !vld_ff || (rsp_ready && last);

   always_comb begin
      vld_in  = vld_ff;
      rr_in   = rr_ff;
      cc_in   = cc_ff;
      addr_in = addr_ff;
      row_in  = row_ff;
      word_in = word_ff;
      if (vld_ff && rsp_ready) begin
         if (last) begin
            vld_in = 1'b0;
         end else if (cc_ff == last_idx) begin
            cc_in   = '0;
            rr_in   = rr_ff + REP_W'(1);
            row_in  = row_ff + stride;
            addr_in = row_ff + stride;
         end else begin
            cc_in   = cc_ff + REP_W'(1);
            addr_in = addr_ff + ADDR_W'(BYTES_PER_PIXEL);
         end
      end
      if (load_valid && load_ready) begin
         vld_in  = 1'b1;
         rr_in   = '0;
         cc_in   = '0;
         addr_in = load.start_addr;
         row_in  = load.start_addr;
         word_in = load.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff   <= rr_in;
      cc_ff   <= cc_in;
      addr_ff <= addr_in;
      row_ff  <= row_in;
      word_ff <= word_in;
   end

   assign rsp_valid                = vld_ff;
   assign rsp_payload.byte_address = addr_ff;
   assign rsp_payload.pixel_word   = word_ff;
   assign rsp_payload.run_last     = last;

endmodule

// ----- design/indexed_pixel_scaler.sv -----
// indexed pixel scaler
// req channel: one item per cycle while req_ready is high; an item is a
// gamma entry write, a palette entry write (colour passed through the gamma
// row and stored packed), a pixel (palette index, raster order) or a frame
// start that rewinds the source position.
// rsp channel: each pixel gives scale*scale framebuffer words, row-major,
// each with its byte address; run_last marks the final replica. A pixel
// whose scaled frame is wider than screen_width gives nothing but still
// advances the position.
// csr port: screen_width at 0x0, scale at 0x4; write only while idle.
// path: a pixel item passes the palette read register, the address multiply
// register and the output register before its first word is offered.
// throughput: table writes and frame starts never wait on stage 2; a pixel
// holds the output register for scale*scale words, one word per cycle while
// rsp_ready is high; a waiting pixel's first word directly follows the last.
// reset: palette reads as black, gamma entries are undefined until written,
// source position at zero, screen_width 320, scale 1.
// when rsp_ready is low the output register holds its word and back-pressure
// reaches req_ready once the two internal stages are full.
module indexed_pixel_scaler #(
   parameter int SOURCE_WIDTH  = ips_pkg::SOURCE_WIDTH_DEF,
   parameter int SOURCE_HEIGHT = ips_pkg::SOURCE_HEIGHT_DEF,
   parameter int MAX_SCALE     = ips_pkg::MAX_SCALE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ips_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ips_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ips_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ips_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ips_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   import ips_pkg::*;

   localparam int COL_W = $clog2(SOURCE_WIDTH);
   localparam int ROW_W = $clog2(SOURCE_HEIGHT);
   localparam int CS_W  = COL_W + SCALE_W;
   localparam int RS_W  = ROW_W + SCALE_W;
   localparam int FIT_W = (CS_W > SW_W) ? CS_W : SW_W;
   localparam int PROD_W = RS_W + SW_W;
   localparam int TAB_W = $clog2(TABLE_DEPTH);

   // configuration
   logic [SW_W-1:0]    screen_width_ff, screen_width_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [SCALE_W-1:0] s_eff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      screen_width_in = screen_width_ff;
      scale_in        = scale_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_SCREEN_WIDTH: screen_width_in = csr_pwdata[SW_W-1:0];
            CSR_SCALE:        scale_in        = csr_pwdata[SCALE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_SCREEN_WIDTH: csr_prdata = CSR_DATA_W'(screen_width_ff);
         CSR_SCALE:        csr_prdata = CSR_DATA_W'(scale_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      priority if (scale_ff == '0) begin
         s_eff = SCALE_W'(1);
      end else if (scale_ff > SCALE_W'(MAX_SCALE)) begin
         s_eff = SCALE_W'(MAX_SCALE);
      end else begin
         s_eff = scale_ff;
      end
   end

   // stage 1: table read data arrives
   logic               accept;
   logic               s1_vld_ff, s1_vld_in;
   req_type            s1_item_ff, s1_item_in;
   logic               s1_hit_r_ff, s1_hit_r_in;
   logic               s1_hit_g_ff, s1_hit_g_in;
   logic               s1_hit_b_ff, s1_hit_b_in;
   logic               s1_hit_pal_ff, s1_hit_pal_in;
   logic [CHAN_W-1:0]  s1_fwd_gamma_ff, s1_fwd_gamma_in;
   logic [WORD_W-1:0]  s1_fwd_pal_ff, s1_fwd_pal_in;
   logic               s1_adv;
   logic               gamma_wr, pal_wr;
   logic [CHAN_W-1:0]  gamma_r_rd, gamma_g_rd, gamma_b_rd;
   logic [CHAN_W-1:0]  gr, gg, gb;
   logic [WORD_W-1:0]  pal_rd, pal_packed, pal_word;
   logic [TABLE_DEPTH-1:0] pal_valid_ff, pal_valid_in;

   // source position
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   // stage 2: address multiply
   logic               s2_vld_ff, s2_vld_in;
   logic [WORD_W-1:0]  s2_word_ff, s2_word_in;
   logic [RS_W-1:0]    s2_rs_ff, s2_rs_in;
   logic [CS_W-1:0]    s2_cs_ff, s2_cs_in;
   logic               s2_fits_ff, s2_fits_in;
   logic               s2_free, s2_adv;
   logic [CS_W-1:0]    span;
   logic               fits;
   logic [SW_W-1:0]    margin_px;
   logic [PROD_W-1:0]  row_pix;
   logic [ADDR_W-1:0]  pix_sum;
   logic [ADDR_W-1:0]  stride;
   rep_load_type       rep_load;
   logic               rep_ready;

   assign accept    = req_valid && req_ready;
   assign gamma_wr  = s1_adv && (s1_item_ff.kind == KIND_GAMMA);
   assign pal_wr    = s1_adv && (s1_item_ff.kind == KIND_PALETTE);
   assign s1_adv    = s1_vld_ff && ((s1_item_ff.kind != KIND_PIXEL) || s2_free);
   assign req_ready = !s1_vld_ff || s1_adv;

   ips_ram #(.WIDTH(CHAN_W), .DEPTH(TABLE_DEPTH)) u_gamma_r (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (s1_item_ff.entry_index),
      .wr_data (s1_item_ff.gamma_value),
      .rd_en   (accept),
      .rd_addr (req_payload.raw_red),
      .rd_data (gamma_r_rd)
   );

   ips_ram #(.WIDTH(CHAN_W), .DEPTH(TABLE_DEPTH)) u_gamma_g (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (s1_item_ff.entry_index),
      .wr_data (s1_item_ff.gamma_value),
      .rd_en   (accept),
      .rd_addr (req_payload.raw_green),
      .rd_data (gamma_g_rd)
   );

   ips_ram #(.WIDTH(CHAN_W), .DEPTH(TABLE_DEPTH)) u_gamma_b (
      .clock   (clock),
      .wr_en   (gamma_wr),
      .wr_addr (s1_item_ff.entry_index),
      .wr_data (s1_item_ff.gamma_value),
      .rd_en   (accept),
      .rd_addr (req_payload.raw_blue),
      .rd_data (gamma_b_rd)
   );

   ips_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (s1_item_ff.entry_index),
      .wr_data (pal_packed),
      .rd_en   (accept),
      .rd_addr (req_payload.entry_index),
      .rd_data (pal_rd)
   );

   // forwarding covers a write landing on the same edge as the read
   assign gr = s1_hit_r_ff ? s1_fwd_gamma_ff : gamma_r_rd;
   assign gg = s1_hit_g_ff ? s1_fwd_gamma_ff : gamma_g_rd;
   assign gb = s1_hit_b_ff ? s1_fwd_gamma_ff : gamma_b_rd;
   assign pal_packed = {gr, gg, gb};

   always_comb begin
      priority if (s1_hit_pal_ff) begin
         pal_word = s1_fwd_pal_ff;
      end else if (pal_valid_ff[s1_item_ff.entry_index[TAB_W-1:0]]) begin
         pal_word = pal_rd;
      end else begin
         pal_word = '0;
      end
   end

   always_comb begin
      s1_vld_in       = s1_vld_ff;
      s1_item_in      = s1_item_ff;
      s1_hit_r_in     = s1_hit_r_ff;
      s1_hit_g_in     = s1_hit_g_ff;
      s1_hit_b_in     = s1_hit_b_ff;
      s1_hit_pal_in   = s1_hit_pal_ff;
      s1_fwd_gamma_in = s1_fwd_gamma_ff;
      s1_fwd_pal_in   = s1_fwd_pal_ff;
      if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      if (accept) begin
         s1_vld_in       = 1'b1;
         s1_item_in      = req_payload;
         s1_hit_r_in     = gamma_wr && (s1_item_ff.entry_index == req_payload.raw_red);
         s1_hit_g_in     = gamma_wr && (s1_item_ff.entry_index == req_payload.raw_green);
         s1_hit_b_in     = gamma_wr && (s1_item_ff.entry_index == req_payload.raw_blue);
         s1_hit_pal_in   = pal_wr && (s1_item_ff.entry_index == req_payload.entry_index);
         s1_fwd_gamma_in = s1_item_ff.gamma_value;
         s1_fwd_pal_in   = pal_packed;
      end
   end

   always_comb begin
      pal_valid_in = pal_valid_ff;
      if (pal_wr) begin
         pal_valid_in[s1_item_ff.entry_index[TAB_W-1:0]] = 1'b1;
      end
   end

   assign span = CS_W'(SOURCE_WIDTH) * s_eff;
   assign fits = FIT_W'(span) <= FIT_W'(screen_width_ff);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      s2_vld_in  = s2_vld_ff;
      s2_word_in = s2_word_ff;
      s2_rs_in   = s2_rs_ff;
      s2_cs_in   = s2_cs_ff;
      s2_fits_in = s2_fits_ff;
      if (s2_adv) begin
         s2_vld_in = 1'b0;
      end
      if (s1_adv && (s1_item_ff.kind == KIND_FRAME)) begin
         col_in = '0;
         row_in = '0;
      end
      if (s1_adv && (s1_item_ff.kind == KIND_PIXEL)) begin
         s2_vld_in  = 1'b1;
         s2_word_in = pal_word;
         s2_rs_in   = RS_W'(row_ff) * RS_W'(s_eff);
         s2_cs_in   = CS_W'(col_ff) * CS_W'(s_eff);
         s2_fits_in = fits;
         if (col_ff == COL_W'(SOURCE_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == ROW_W'(SOURCE_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s2_adv  = s2_vld_ff && (!s2_fits_ff || rep_ready);
   assign s2_free = !s2_vld_ff || s2_adv;

   assign margin_px = screen_width_ff - SW_W'(span);
   assign row_pix   = PROD_W'(s2_rs_ff) * PROD_W'(screen_width_ff);
   assign pix_sum   = ADDR_W'(row_pix) + ADDR_W'(s2_cs_ff);
   assign rep_load.start_addr = (pix_sum << BPP_SHIFT) + ADDR_W'({margin_px, 1'b0});
   assign rep_load.word       = s2_word_ff;
   assign stride = ADDR_W'({screen_width_ff, 2'b00});

   ips_replicator u_replicator (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (s2_vld_ff && s2_fits_ff),
      .load_ready  (rep_ready),
      .load        (rep_load),
      .s_eff       (s_eff),
      .stride      (stride),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff <= SCREEN_WIDTH_RESET;
         scale_ff        <= SCALE_RESET;
         s1_vld_ff       <= 1'b0;
         s2_vld_ff       <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         pal_valid_ff    <= '0;
      end else begin
         screen_width_ff <= screen_width_in;
         scale_ff        <= scale_in;
         s1_vld_ff       <= s1_vld_in;
         s2_vld_ff       <= s2_vld_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         pal_valid_ff    <= pal_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff      <= s1_item_in;
      s1_hit_r_ff     <= s1_hit_r_in;
      s1_hit_g_ff     <= s1_hit_g_in;
      s1_hit_b_ff     <= s1_hit_b_in;
      s1_hit_pal_ff   <= s1_hit_pal_in;
      s1_fwd_gamma_ff <= s1_fwd_gamma_in;
      s1_fwd_pal_ff   <= s1_fwd_pal_in;
      s2_word_ff      <= s2_word_in;
      s2_rs_ff        <= s2_rs_in;
      s2_cs_ff        <= s2_cs_in;
      s2_fits_ff      <= s2_fits_in;
   end

endmodule

// ----- design/ips_checker.sv -----
module ips_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ips_pkg::rsp_type rsp_payload
);

   import ips_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp item changed");

   a_run_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.run_last |=> rsp_valid)
      else $error("replica run broken off");

   a_run_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.run_last
      |=> rsp_payload.pixel_word == $past(rsp_payload.pixel_word))
      else $error("pixel word changed within a run");

endmodule

bind indexed_pixel_scaler ips_checker u_ips_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
